FILE: hdl/cpd_pkg.sv
// Shared types and constants for the consecutive packet dedup block.
// No dependencies; used by every module under hdl except cpd_ram.
package cpd_pkg;

   localparam int STORE_BYTES = 4096;
   localparam int ADDR_W      = $clog2(STORE_BYTES);
   localparam int LEN_W       = 16;
   localparam int SEC_W       = 32;
   localparam int USEC_W      = 20;
   localparam int BYTE_W      = 8;
   localparam int COUNT_W     = 32;

   localparam int OUTQ_DEPTH  = 3;
   localparam int OUTQ_PTR_W  = $clog2(OUTQ_DEPTH);
   localparam int OUTQ_CNT_W  = $clog2(OUTQ_DEPTH + 1);

   localparam logic [LEN_W:0] STORE_LIMIT = (LEN_W + 1)'(STORE_BYTES);

   typedef enum logic {
      OP_HEADER = 1'b0,
      OP_DATA   = 1'b1
   } opcode_type;

   typedef struct packed {
      logic              valid;
      logic              hdr;
      logic              cmp;
      logic              finish;
      logic              hmatch;
      logic              over;
      logic [BYTE_W-1:0] data;
   } cmp_word_type;

   typedef struct packed {
      logic               is_duplicate;
      logic               oversize;
      logic [COUNT_W-1:0] dupe_count;
   } result_type;

endpackage

FILE: hdl/cpd_ram.sv
// Generic single-clock RAM: one write port, one registered read port.
// Read-first: a read and write to the same address return the old word.
module cpd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/cpd_track.sv
// Front stage: header registers, byte index and store addressing.
// Depends on cpd_pkg; feeds cpd_cmp with one compare word per access.
module cpd_track (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic                          opcode,
   input  logic [cpd_pkg::SEC_W-1:0]     ts_seconds,
   input  logic [cpd_pkg::USEC_W-1:0]    ts_micros,
   input  logic [cpd_pkg::LEN_W-1:0]     captured_length,
   input  logic [cpd_pkg::LEN_W-1:0]     wire_length,
   input  logic [cpd_pkg::BYTE_W-1:0]    data_byte,
   output logic                          ram_we,
   output logic [cpd_pkg::ADDR_W-1:0]    ram_addr,
   output cpd_pkg::cmp_word_type         s1
);

   logic [cpd_pkg::SEC_W-1:0]  prev_sec_ff, prev_sec_in;
   logic [cpd_pkg::USEC_W-1:0] prev_usec_ff, prev_usec_in;
   logic [cpd_pkg::LEN_W-1:0]  prev_cap_ff, prev_cap_in;
   logic [cpd_pkg::LEN_W-1:0]  prev_wire_ff, prev_wire_in;
   logic                       prev_valid_ff, prev_valid_in;
   logic                       hmatch_ff, hmatch_in;
   logic [cpd_pkg::LEN_W-1:0]  idx_ff, idx_in;
   logic [cpd_pkg::LEN_W-1:0]  len_ff, len_in;
   cpd_pkg::cmp_word_type      s1_ff, s1_in;

   logic                       is_data;
   logic                       in_prog;
   logic                       in_store;
   logic                       len_over;
   logic [cpd_pkg::LEN_W-1:0]  idx_inc;
   logic                       last;
   logic                       hdr_match;

   always_comb begin
      is_data   = (cpd_pkg::opcode_type'(opcode) == cpd_pkg::OP_DATA);
      in_prog   = idx_ff < len_ff;
      in_store  = {1'b0, idx_ff} < cpd_pkg::STORE_LIMIT;
      len_over  = {1'b0, len_ff} > cpd_pkg::STORE_LIMIT;
      idx_inc   = idx_ff + cpd_pkg::LEN_W'(1);
      last      = idx_inc == len_ff;
      hdr_match = prev_valid_ff && (ts_seconds == prev_sec_ff) &&
                  (ts_micros == prev_usec_ff) && (captured_length == prev_cap_ff) &&
                  (wire_length == prev_wire_ff);

      prev_sec_in   = prev_sec_ff;
      prev_usec_in  = prev_usec_ff;
      prev_cap_in   = prev_cap_ff;
      prev_wire_in  = prev_wire_ff;
      prev_valid_in = prev_valid_ff;
      hmatch_in     = hmatch_ff;
      idx_in        = idx_ff;
      len_in        = len_ff;
      s1_in         = '0;
      s1_in.data    = data_byte;

      if (accept && !is_data) begin
         prev_sec_in   = ts_seconds;
         prev_usec_in  = ts_micros;
         prev_cap_in   = captured_length;
         prev_wire_in  = wire_length;
         prev_valid_in = (captured_length == '0);
         hmatch_in     = hdr_match;
         idx_in        = '0;
         len_in        = captured_length;
         s1_in.valid   = 1'b1;
         s1_in.hdr     = 1'b1;
         s1_in.finish  = (captured_length == '0);
         s1_in.hmatch  = hdr_match;
      end else if (accept && in_prog) begin
         idx_in        = idx_inc;
         s1_in.valid   = 1'b1;
         s1_in.cmp     = in_store;
         s1_in.finish  = last;
         s1_in.hmatch  = hmatch_ff;
         s1_in.over    = len_over;
         if (last) begin
            prev_valid_in = !len_over;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_sec_ff   <= '0;
         prev_usec_ff  <= '0;
         prev_cap_ff   <= '0;
         prev_wire_ff  <= '0;
         prev_valid_ff <= 1'b0;
         hmatch_ff     <= 1'b0;
         idx_ff        <= '0;
         len_ff        <= '0;
         s1_ff         <= '0;
      end else begin
         prev_sec_ff   <= prev_sec_in;
         prev_usec_ff  <= prev_usec_in;
         prev_cap_ff   <= prev_cap_in;
         prev_wire_ff  <= prev_wire_in;
         prev_valid_ff <= prev_valid_in;
         hmatch_ff     <= hmatch_in;
         idx_ff        <= idx_in;
         len_ff        <= len_in;
         s1_ff         <= s1_in;
      end
   end

   assign ram_we   = accept && is_data && in_prog && in_store;
   assign ram_addr = idx_ff[cpd_pkg::ADDR_W-1:0];
   assign s1       = s1_ff;

endmodule

FILE: hdl/cpd_cmp.sv
// Compare stage: checks the stored byte against the new one, keeps the match
// flag and the duplicate count, and forms the result. Depends on cpd_pkg.
module cpd_cmp (
   input  logic                        clock,
   input  logic                        reset,
   input  cpd_pkg::cmp_word_type       s1,
   input  logic [cpd_pkg::BYTE_W-1:0]  rd_data,
   output logic                        push,
   output cpd_pkg::result_type         res
);

   logic                         bm_ff, bm_in;
   logic [cpd_pkg::COUNT_W-1:0]  cnt_ff, cnt_in;
   logic                         bm_now;
   logic                         dup;
   logic [cpd_pkg::COUNT_W-1:0]  cnt_now;

   always_comb begin
      bm_now  = (s1.hdr || bm_ff) && !(s1.cmp && (rd_data != s1.data));
      dup     = s1.finish && s1.hmatch && bm_now && !s1.over;
      cnt_now = cnt_ff + cpd_pkg::COUNT_W'(dup);
      bm_in   = bm_ff;
      cnt_in  = cnt_ff;
      if (s1.valid) begin
         bm_in  = bm_now;
         cnt_in = cnt_now;
      end
      push             = s1.valid && s1.finish;
      res.is_duplicate = dup;
      res.oversize     = s1.over;
      res.dupe_count   = cnt_now;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bm_ff  <= 1'b1;
         cnt_ff <= '0;
      end else begin
         bm_ff  <= bm_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

FILE: hdl/cpd_outq.sv
// Small result queue between the compare stage and the result channel.
// Depends on cpd_pkg.
module cpd_outq (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              push,
   input  cpd_pkg::result_type               push_res,
   input  logic                              pop,
   output logic                              head_valid,
   output cpd_pkg::result_type               head,
   output logic [cpd_pkg::OUTQ_CNT_W-1:0]    count
);

   cpd_pkg::result_type                  entry_ff [cpd_pkg::OUTQ_DEPTH];
   logic [cpd_pkg::OUTQ_PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [cpd_pkg::OUTQ_PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [cpd_pkg::OUTQ_CNT_W-1:0]       count_ff, count_in;
   logic                                 do_pop;

   function automatic logic [cpd_pkg::OUTQ_PTR_W-1:0] ptr_next(
      input logic [cpd_pkg::OUTQ_PTR_W-1:0] p);
      if (p == cpd_pkg::OUTQ_PTR_W'(cpd_pkg::OUTQ_DEPTH - 1)) begin
         return '0;
      end
      return p + cpd_pkg::OUTQ_PTR_W'(1);
   endfunction

   always_comb begin
      do_pop    = pop && (count_ff != '0);
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + cpd_pkg::OUTQ_CNT_W'(push) - cpd_pkg::OUTQ_CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_res;
      end
   end

   assign head_valid = (count_ff != '0);
   assign head       = entry_ff[rd_ptr_ff];
   assign count      = count_ff;

endmodule

FILE: hdl/consecutive_packet_dedup.sv
// Top level of the consecutive packet dedup block.
// Uses cpd_pkg, cpd_track, cpd_ram, cpd_cmp and cpd_outq.
//
// Usage: the req_ channel carries one word per cycle. A header word
// (opcode 0) gives timestamp, captured and wire length; the captured bytes
// follow as data words (opcode 1), one byte each. The rsp_ channel gives one
// word per completed packet: on its last byte, or on the header when the
// captured length is zero. A packet is a duplicate when header and bytes
// equal the previous completed packet; packets over the byte store size are
// flagged oversize and never count. Stray data words produce nothing.
// A result reaches rsp_ through the compare-word register and the result
// queue. Throughput: one word per cycle while req_ready is high, set by one
// read-compare-write of the byte store per data word via its registered read port.
// A three-word result queue decouples the sides; req_ready drops only when
// results already in flight would fill it, so a stalled receiver holds the
// input after at most three pending results.
// Reset (synchronous, active high) clears header state, the match flags and
// the duplicate count; the byte store needs no clearing and is ready at once.
module consecutive_packet_dedup (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_opcode,
   input  logic [cpd_pkg::SEC_W-1:0]     req_ts_seconds,
   input  logic [cpd_pkg::USEC_W-1:0]    req_ts_micros,
   input  logic [cpd_pkg::LEN_W-1:0]     req_captured_length,
   input  logic [cpd_pkg::LEN_W-1:0]     req_wire_length,
   input  logic [cpd_pkg::BYTE_W-1:0]    req_data_byte,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_is_duplicate,
   output logic                          rsp_oversize,
   output logic [cpd_pkg::COUNT_W-1:0]   rsp_dupe_count
);

   logic                               accept;
   logic                               ram_we;
   logic [cpd_pkg::ADDR_W-1:0]         ram_addr;
   logic [cpd_pkg::BYTE_W-1:0]         rd_data;
   cpd_pkg::cmp_word_type              s1;
   logic                               push;
   cpd_pkg::result_type                push_res;
   cpd_pkg::result_type                head;
   logic [cpd_pkg::OUTQ_CNT_W-1:0]     q_count;
   logic                               pend;
   logic [cpd_pkg::OUTQ_CNT_W:0]       in_flight;

   assign accept    = req_valid && req_ready;
   assign pend      = s1.valid && s1.finish;
   assign in_flight = {1'b0, q_count} + (cpd_pkg::OUTQ_CNT_W + 1)'(pend);
   assign req_ready = in_flight < (cpd_pkg::OUTQ_CNT_W + 1)'(cpd_pkg::OUTQ_DEPTH);

   cpd_track u_track (
      .clock           (clock),
      .reset           (reset),
      .accept          (accept),
      .opcode          (req_opcode),
      .ts_seconds      (req_ts_seconds),
      .ts_micros       (req_ts_micros),
      .captured_length (req_captured_length),
      .wire_length     (req_wire_length),
      .data_byte       (req_data_byte),
      .ram_we          (ram_we),
      .ram_addr        (ram_addr),
      .s1              (s1)
   );

   cpd_ram #(
      .WIDTH (cpd_pkg::BYTE_W),
      .DEPTH (cpd_pkg::STORE_BYTES)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_addr),
      .wr_data (req_data_byte),
      .rd_en   (ram_we),
      .rd_addr (ram_addr),
      .rd_data (rd_data)
   );

   cpd_cmp u_cmp (
      .clock   (clock),
      .reset   (reset),
      .s1      (s1),
      .rd_data (rd_data),
      .push    (push),
      .res     (push_res)
   );

   cpd_outq u_outq (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_res   (push_res),
      .pop        (rsp_ready),
      .head_valid (rsp_valid),
      .head       (head),
      .count      (q_count)
   );

   assign rsp_is_duplicate = head.is_duplicate;
   assign rsp_oversize     = head.oversize;
   assign rsp_dupe_count   = head.dupe_count;

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (push && !(rsp_valid && rsp_ready)) |->
         (q_count < cpd_pkg::OUTQ_CNT_W'(cpd_pkg::OUTQ_DEPTH)))
      else $error("result queue overflow");

   a_empty_header_result: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_opcode == cpd_pkg::OP_HEADER) && (req_captured_length == '0))
         |=> push)
      else $error("zero-length packet gave no result");

   a_oversize_not_dup: assert property (@(posedge clock) disable iff (reset)
      push |-> !(push_res.is_duplicate && push_res.oversize))
      else $error("oversize packet flagged duplicate");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (push && $past(push) && !$past(reset) && push_res.is_duplicate) |->
         (push_res.dupe_count != $past(push_res.dupe_count)))
      else $error("duplicate did not advance count");
`endif

endmodule
